// ===== sv/ffha_pkg.sv =====
// shared constants and control bundles for the first-fit heap allocator
package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 24;

    // fixed widths of the beat fields
    localparam int REQ_W  = 10;
    localparam int ADDR_W = 10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // control of the shared add/compare unit
    typedef struct packed {
        logic add_hdr;
        logic sub;
    } alu_ctl_t;

    // write strobes for the header store
    typedef struct packed {
        logic size_en;
        logic free_en;
        logic free_bit;
    } wr_ctl_t;

endpackage

// ===== sv/ffha_alu.sv =====
// shared add/subtract unit with header offset and a less-than compare
module ffha_alu
    import ffha_pkg::*;
#(
    parameter int CW           = 12,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic [CW-1:0] a,
    input  logic [CW-1:0] b,
    input  logic [CW-1:0] c,
    input  alu_ctl_t      ctl,
    output logic [CW-1:0] sum,
    output logic          lt
);

    logic [CW-1:0] hdr_v;

    assign hdr_v = ctl.add_hdr ? CW'(HEADER_BYTES) : '0;

    // sub: a - b, otherwise a + b; the header offset is subtracted or added only with add_hdr
    always_comb
    begin
        if (ctl.sub)
        begin
            sum = a - b - hdr_v;
        end
        else
        begin
            sum = a + b + hdr_v;
        end
    end

    assign lt = (sum < c);

endmodule

// ===== sv/ffha_mem.sv =====
// header store: payload size and free mark per heap offset, registered read
module ffha_mem
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(HEAP_BYTES)-1:0] rd_addr,
    output logic [$clog2(HEAP_BYTES)-1:0] rd_size,
    output logic                          rd_free,
    input  logic [$clog2(HEAP_BYTES)-1:0] wr_addr,
    input  logic [$clog2(HEAP_BYTES)-1:0] wr_size,
    input  wr_ctl_t                       wr_ctl
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam logic [AW-1:0] RESET_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

    logic [AW-1:0] size_mem [HEAP_BYTES];
    logic          free_mem [HEAP_BYTES];

    logic [AW-1:0] rd_size_raw_reg;
    logic          rd_free_raw_reg;
    logic          size0_ok_reg;
    logic          free0_ok_reg;
    logic          size_dflt_reg;
    logic          free_dflt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.size_en)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        if (wr_ctl.free_en)
        begin
            free_mem[wr_addr] <= wr_ctl.free_bit;
        end
        rd_size_raw_reg <= size_mem[rd_addr];
        rd_free_raw_reg <= free_mem[rd_addr];
    end

    // entry 0 reads as the single free block until it is first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size0_ok_reg  <= 1'b0;
            free0_ok_reg  <= 1'b0;
            size_dflt_reg <= 1'b0;
            free_dflt_reg <= 1'b0;
        end
        else
        begin
            if (wr_ctl.size_en && (wr_addr == '0))
            begin
                size0_ok_reg <= 1'b1;
            end
            if (wr_ctl.free_en && (wr_addr == '0))
            begin
                free0_ok_reg <= 1'b1;
            end
            size_dflt_reg <= (rd_addr == '0) && !size0_ok_reg;
            free_dflt_reg <= (rd_addr == '0) && !free0_ok_reg;
        end
    end

    assign rd_size = size_dflt_reg ? RESET_SIZE : rd_size_raw_reg;
    assign rd_free = free_dflt_reg ? 1'b1 : rd_free_raw_reg;

endmodule

// ===== sv/ffha_seq.sv =====
// sequencer for block walk, split, free marking and coalescing, with output register
module ffha_seq
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int CW           = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [REQ_W-1:0]              request_size,
    input  logic [ADDR_W-1:0]             release_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ADDR_W-1:0]             payload_address,
    output logic                          success,
    output logic [$clog2(HEAP_BYTES)-1:0] rd_addr,
    input  logic [$clog2(HEAP_BYTES)-1:0] mem_size,
    input  logic                          mem_free,
    output logic [$clog2(HEAP_BYTES)-1:0] wr_addr,
    output logic [$clog2(HEAP_BYTES)-1:0] wr_size,
    output wr_ctl_t                       wr_ctl,
    output logic [CW-1:0]                 alu_a,
    output logic [CW-1:0]                 alu_b,
    output logic [CW-1:0]                 alu_c,
    output alu_ctl_t                      alu_ctl,
    input  logic [CW-1:0]                 alu_sum,
    input  logic                          alu_lt
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_FIT,
        S_A_NEXT,
        S_A_SPLIT,
        S_A_NB,
        S_A_NSZ,
        S_A_HSZ,
        S_A_ADDR,
        S_F_CHK,
        S_F_MARK,
        S_C_RD,
        S_C_LD,
        S_C_NX,
        S_C_LDN,
        S_C_MRG,
        S_RESP
    } state_t;

    state_t            state_reg,     state_next;
    logic [AW-1:0]     cur_reg,       cur_next;
    logic [AW-1:0]     nxt_reg,       nxt_next;
    logic [AW-1:0]     sz_reg,        sz_next;
    logic [AW-1:0]     nsz_reg,       nsz_next;
    logic              fr_reg,        fr_next;
    logic [REQ_W-1:0]  req_reg,       req_next;
    logic [ADDR_W-1:0] rel_reg,       rel_next;
    logic [ADDR_W-1:0] res_addr_reg,  res_addr_next;
    logic              res_ok_reg,    res_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg,  out_addr_next;
    logic              out_ok_reg,    out_ok_next;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        sz_next        = sz_reg;
        nsz_next       = nsz_reg;
        fr_next        = fr_reg;
        req_next       = req_reg;
        rel_next       = rel_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        out_addr_next  = out_addr_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg && out_stall;

        in_stall = 1'b1;
        rd_addr  = cur_reg;
        wr_addr  = cur_reg;
        wr_size  = AW'(req_reg);
        wr_ctl   = '0;
        alu_a    = '0;
        alu_b    = '0;
        alu_c    = HEAP_C;
        alu_ctl  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                rd_addr  = '0;
                if (in_valid)
                begin
                    req_next = request_size;
                    rel_next = release_address;
                    cur_next = '0;
                    if (cmd == CMD_ALLOC)
                    begin
                        state_next = S_A_FIT;
                    end
                    else
                    begin
                        state_next = S_F_CHK;
                    end
                end
            end

            // walk: is the block just read free and large enough
            S_A_FIT:
            begin
                alu_a   = CW'(mem_size);
                alu_c   = CW'(req_reg);
                sz_next = mem_size;
                if (mem_free && !alu_lt)
                begin
                    state_next = S_A_SPLIT;
                end
                else
                begin
                    state_next = S_A_NEXT;
                end
            end

            S_A_NEXT:
            begin
                alu_a           = CW'(cur_reg);
                alu_b           = CW'(sz_reg);
                alu_ctl.add_hdr = 1'b1;
                if (alu_lt)
                begin
                    cur_next   = alu_sum[AW-1:0];
                    rd_addr    = alu_sum[AW-1:0];
                    state_next = S_A_FIT;
                end
                else
                begin
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                    state_next    = S_RESP;
                end
            end

            // mark used, then split if the tail exceeds a header
            S_A_SPLIT:
            begin
                wr_ctl.free_en  = 1'b1;
                wr_ctl.free_bit = 1'b0;
                alu_a           = CW'(req_reg);
                alu_c           = CW'(sz_reg);
                alu_ctl.add_hdr = 1'b1;
                if (alu_lt)
                begin
                    state_next = S_A_NB;
                end
                else
                begin
                    state_next = S_A_ADDR;
                end
            end

            S_A_NB:
            begin
                alu_a           = CW'(cur_reg);
                alu_b           = CW'(req_reg);
                alu_ctl.add_hdr = 1'b1;
                if (alu_lt)
                begin
                    nxt_next   = alu_sum[AW-1:0];
                    state_next = S_A_NSZ;
                end
                else
                begin
                    state_next = S_A_ADDR;
                end
            end

            S_A_NSZ:
            begin
                alu_a           = CW'(sz_reg);
                alu_b           = CW'(req_reg);
                alu_ctl.add_hdr = 1'b1;
                alu_ctl.sub     = 1'b1;
                wr_addr         = nxt_reg;
                wr_size         = alu_sum[AW-1:0];
                wr_ctl.size_en  = 1'b1;
                wr_ctl.free_en  = 1'b1;
                wr_ctl.free_bit = 1'b1;
                state_next      = S_A_HSZ;
            end

            S_A_HSZ:
            begin
                wr_size        = AW'(req_reg);
                wr_ctl.size_en = 1'b1;
                state_next     = S_A_ADDR;
            end

            S_A_ADDR:
            begin
                alu_a           = CW'(cur_reg);
                alu_ctl.add_hdr = 1'b1;
                res_addr_next   = alu_sum[ADDR_W-1:0];
                res_ok_next     = 1'b1;
                state_next      = S_RESP;
            end

            // header offset of the released payload, wraps high when below a header
            S_F_CHK:
            begin
                alu_a           = CW'(rel_reg);
                alu_ctl.add_hdr = 1'b1;
                alu_ctl.sub     = 1'b1;
                res_addr_next   = '0;
                res_ok_next     = 1'b1;
                if (alu_lt)
                begin
                    cur_next   = alu_sum[AW-1:0];
                    state_next = S_F_MARK;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_F_MARK:
            begin
                wr_ctl.free_en  = 1'b1;
                wr_ctl.free_bit = 1'b1;
                cur_next        = '0;
                state_next      = S_C_RD;
            end

            S_C_RD:
            begin
                rd_addr    = '0;
                state_next = S_C_LD;
            end

            S_C_LD:
            begin
                sz_next    = mem_size;
                fr_next    = mem_free;
                state_next = S_C_NX;
            end

            S_C_NX:
            begin
                alu_a           = CW'(cur_reg);
                alu_b           = CW'(sz_reg);
                alu_ctl.add_hdr = 1'b1;
                if (alu_lt)
                begin
                    nxt_next   = alu_sum[AW-1:0];
                    rd_addr    = alu_sum[AW-1:0];
                    state_next = S_C_LDN;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_C_LDN:
            begin
                if (fr_reg && mem_free)
                begin
                    nsz_next   = mem_size;
                    state_next = S_C_MRG;
                end
                else
                begin
                    cur_next   = nxt_reg;
                    sz_next    = mem_size;
                    fr_next    = mem_free;
                    state_next = S_C_NX;
                end
            end

            S_C_MRG:
            begin
                alu_a           = CW'(sz_reg);
                alu_b           = CW'(nsz_reg);
                alu_ctl.add_hdr = 1'b1;
                sz_next         = alu_sum[AW-1:0];
                wr_size         = alu_sum[AW-1:0];
                wr_ctl.size_en  = 1'b1;
                state_next      = S_C_NX;
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            nxt_reg       <= '0;
            sz_reg        <= '0;
            nsz_reg       <= '0;
            fr_reg        <= 1'b0;
            req_reg       <= '0;
            rel_reg       <= '0;
            res_addr_reg  <= '0;
            res_ok_reg    <= 1'b0;
            out_addr_reg  <= '0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            nxt_reg       <= nxt_next;
            sz_reg        <= sz_next;
            nsz_reg       <= nsz_next;
            fr_reg        <= fr_next;
            req_reg       <= req_next;
            rel_reg       <= rel_next;
            res_addr_reg  <= res_addr_next;
            res_ok_reg    <= res_ok_next;
            out_addr_reg  <= out_addr_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_address = out_addr_reg;
    assign success         = out_ok_reg;

    a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result beat raised outside the response step");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_addr_reg == '0))
        else $error("failed allocation carries an address");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted beat left the sequencer idle");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!wr_ctl.size_en && !wr_ctl.free_en))
        else $error("header store written while idle");

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// top level of the first-fit heap allocator with split and coalesce
//
//  channel | beat fields                               | handshake
//  --------+-------------------------------------------+---------------------
//  in      | cmd, request_size, release_address        | in_valid / in_stall
//  out     | payload_address, success                  | out_valid / out_stall
//
// allocate: each block header passed over is read and checked, then the header that
//   fits is marked used, split if the tail exceeds a header, and its address formed,
//   then the response; a failed walk goes to the response after its last header
// free: the released header is checked and marked free, block 0 is loaded, then the
//   coalescing walk steps over blocks and merges each free block with a free successor
//   until the end of the heap, then the response; a null or short address goes straight to the response
// the walk steps read block headers from the header store and use the shared adder
// reset: asynchronous, active low; block 0 reads as the whole free heap at once
// in_stall is high from acceptance until the result is loaded into the output
//   register; a stalled result beat holds while the next beat is taken
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [REQ_W-1:0]  request_size,
    input  logic [ADDR_W-1:0] release_address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] payload_address,
    output logic              success
);

    // offsets fit in AW bits; the shared unit is wide enough for any field,
    // header sum and the wrap of a release address below a header
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int CW = ((AW > ADDR_W) ? AW : ADDR_W) + 2;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] mem_size;
    logic          mem_free;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] wr_size;
    wr_ctl_t       wr_ctl;
    logic [CW-1:0] alu_a;
    logic [CW-1:0] alu_b;
    logic [CW-1:0] alu_c;
    alu_ctl_t      alu_ctl;
    logic [CW-1:0] alu_sum;
    logic          alu_lt;

    // control: walk, split, free mark and merge steps, plus result register
    ffha_seq #(
        .HEAP_BYTES   (HEAP_BYTES),
        .CW           (CW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .request_size    (request_size),
        .release_address (release_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .payload_address (payload_address),
        .success         (success),
        .rd_addr         (rd_addr),
        .mem_size        (mem_size),
        .mem_free        (mem_free),
        .wr_addr         (wr_addr),
        .wr_size         (wr_size),
        .wr_ctl          (wr_ctl),
        .alu_a           (alu_a),
        .alu_b           (alu_b),
        .alu_c           (alu_c),
        .alu_ctl         (alu_ctl),
        .alu_sum         (alu_sum),
        .alu_lt          (alu_lt)
    );

    // one adder with header offset and compare, shared by every step that adds or compares
    ffha_alu #(
        .CW           (CW),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .ctl (alu_ctl),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    // block headers indexed by heap offset
    ffha_mem #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_size (mem_size),
        .rd_free (mem_free),
        .wr_addr (wr_addr),
        .wr_size (wr_size),
        .wr_ctl  (wr_ctl)
    );

endmodule
